// ----- src/asc_pkg.sv -----
`default_nettype none
package asc_pkg;

	localparam int TBL_SLOTS = 8;
	localparam int SLOT_W = 3;
	localparam int CFG_IDX_W = 8;
	localparam int SAMPLE_W = 10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCAN_ENABLE    = 8'd0,
		CFG_CHANNEL_TABLE  = 8'd1,
		CFG_REFERENCE_BITS = 8'd2,
		CFG_WIDE_CHANNELS  = 8'd3
	} cfg_reg_t;

	typedef enum logic {
		KIND_CONVERSION = 1'b0,
		KIND_READ       = 1'b1
	} item_kind_t;

	localparam logic [7:0] CH_UNUSED = 8'hFF;
	localparam logic [7:0] CH_LIMIT_WIDE = 8'd16;
	localparam logic [7:0] CH_LIMIT_NARROW = 8'd8;
	localparam int CH_HIGH_BIT = 3;

	localparam logic [63:0] CHAN_TBL_RST = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [7:0] REF_BITS_RST = 8'd64;
	localparam logic WIDE_RST = 1'b1;

endpackage
`default_nettype wire

// ----- src/adc_scan_sequencer_top.sv -----
// done is registered from the stage-1 valid, itself registered from the accepted start; it is high for one cycle.
// A new item is not taken while busy is high; busy covers the sample RAM read.
// Next-slot search is a combinational priority pick over the slot table.
// Reset clears config to defaults, pointer to slot 0 and all per-slot valid bits,
// so every stored sample reads as zero until written. The receiver cannot stall.
`default_nettype none
module adc_scan_sequencer_top #(
	parameter int SLOTS = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              kind,
	input  wire logic [asc_pkg::SAMPLE_W-1:0]      sample,
	input  wire logic [7:0]                        read_index,
	output logic                                   done,
	output logic      [asc_pkg::SAMPLE_W-1:0]      read_value,
	output logic      [7:0]                        mux_byte,
	output logic                                   high_mux_bit,
	output logic                                   start_next,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [asc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [63:0]                       cfg_data
);

	localparam int AW = SLOTS > 1 ? $clog2(SLOTS) : 1;
	localparam int CW = asc_pkg::SLOT_W + 1;

	// configuration
	logic        scan_en_q;
	logic [63:0] chan_tbl_q;
	logic [7:0]  ref_bits_q;
	logic        wide_q;

	logic [AW-1:0]    ptr_q;
	logic [SLOTS-1:0] vld_q;

	logic       vld_s1;
	logic       kind_s1;
	logic       rd_ok_s1;
	logic       start_s1;
	logic [7:0] mux_s1;
	logic       hi_s1;

	logic accept;
	logic is_read;
	logic conv_we;
	logic rd_in_range;
	logic rd_ok;
	logic [7:0] chan_a [asc_pkg::TBL_SLOTS];
	logic [7:0] rd_ch;
	logic [7:0] ch_limit;
	logic found;
	logic [AW-1:0] nxt_ptr;
	logic [7:0] nxt_ch;
	logic [asc_pkg::SAMPLE_W-1:0] ram_rdata;

	assign busy = vld_s1;
	assign cfg_ready = ~vld_s1;
	assign accept = start & ~busy;
	assign is_read = (kind == asc_pkg::KIND_READ);
	assign conv_we = accept & ~is_read & scan_en_q;

	always_comb begin
		for (int i = 0; i < asc_pkg::TBL_SLOTS; i++) begin
			chan_a[i] = chan_tbl_q[8*i +: 8];
		end
	end

	// read validity
	assign ch_limit = wide_q ? asc_pkg::CH_LIMIT_WIDE : asc_pkg::CH_LIMIT_NARROW;
	assign rd_in_range = read_index < 8'(SLOTS);
	assign rd_ch = chan_a[read_index[asc_pkg::SLOT_W-1:0]];
	assign rd_ok = rd_in_range && (rd_ch < ch_limit) && vld_q[AW'(read_index)];

	// next used slot after the current one, wrapping; smallest step wins
	always_comb begin
		logic [CW-1:0] cand;
		found = 1'b0;
		nxt_ptr = ptr_q;
		nxt_ch = '0;
		for (int k = SLOTS; k >= 1; k--) begin
			cand = CW'(ptr_q) + CW'(k);
			if (cand >= CW'(SLOTS)) begin
				cand = cand - CW'(SLOTS);
			end
			if (chan_a[cand[asc_pkg::SLOT_W-1:0]] != asc_pkg::CH_UNUSED) begin
				found = 1'b1;
				nxt_ptr = AW'(cand);
				nxt_ch = chan_a[cand[asc_pkg::SLOT_W-1:0]];
			end
		end
	end

	asc_ram #(
		.WIDTH(asc_pkg::SAMPLE_W),
		.DEPTH(SLOTS)
	) u_store (
		.clk  (clk),
		.we   (conv_we),
		.waddr(ptr_q),
		.wdata(sample),
		.re   (accept & is_read),
		.raddr(AW'(read_index)),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_en_q  <= 1'b0;
			chan_tbl_q <= asc_pkg::CHAN_TBL_RST;
			ref_bits_q <= asc_pkg::REF_BITS_RST;
			wide_q     <= asc_pkg::WIDE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				asc_pkg::CFG_SCAN_ENABLE:    scan_en_q  <= cfg_data[0];
				asc_pkg::CFG_CHANNEL_TABLE:  chan_tbl_q <= cfg_data;
				asc_pkg::CFG_REFERENCE_BITS: ref_bits_q <= cfg_data[7:0];
				asc_pkg::CFG_WIDE_CHANNELS:  wide_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			vld_q    <= '0;
			vld_s1   <= 1'b0;
			kind_s1  <= 1'b0;
			rd_ok_s1 <= 1'b0;
			start_s1 <= 1'b0;
			mux_s1   <= '0;
			hi_s1    <= 1'b0;
		end else begin
			vld_s1 <= accept;
			if (accept) begin
				kind_s1  <= is_read;
				rd_ok_s1 <= is_read & rd_ok;
				start_s1 <= conv_we & found;
				mux_s1   <= (conv_we & found) ? ({5'd0, nxt_ch[2:0]} | ref_bits_q) : '0;
				hi_s1    <= conv_we & found & wide_q & nxt_ch[asc_pkg::CH_HIGH_BIT];
			end
			if (conv_we) begin
				vld_q[ptr_q] <= 1'b1;
				if (found) begin
					ptr_q <= nxt_ptr;
				end
			end
		end
	end

	// result register: one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done         <= 1'b0;
			read_value   <= '0;
			mux_byte     <= '0;
			high_mux_bit <= 1'b0;
			start_next   <= 1'b0;
		end else begin
			done <= vld_s1;
			if (vld_s1) begin
				read_value   <= (kind_s1 && rd_ok_s1) ? ram_rdata : '0;
				mux_byte     <= mux_s1;
				high_mux_bit <= hi_s1;
				start_next   <= start_s1;
			end
		end
	end

	a_done_after_s1: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |=> done && !vld_s1)
		else $error("result strobe missing after stage 1");

	a_hi_needs_start: assert property (@(posedge clk) disable iff (!arst_n)
		done && high_mux_bit |-> start_next)
		else $error("high mux bit without a conversion start");

	a_read_excl_start: assert property (@(posedge clk) disable iff (!arst_n)
		(read_value != '0) |-> !start_next && !high_mux_bit)
		else $error("read result and conversion start together");

endmodule
`default_nettype wire

// ----- src/asc_ram.sv -----
`default_nettype none
module asc_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 3;
	localparam logic [7:0] CFG_UNMAPPED = 8'hFF;

	typedef struct packed {
		logic [asc_pkg::SAMPLE_W-1:0] read_value;
		logic [7:0]          mux_byte;
		logic                high_mux_bit;
		logic                start_next;
	} scan_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic                kind = 1'b0;
	logic [asc_pkg::SAMPLE_W-1:0] sample = '0;
	logic [7:0]          read_index = '0;
	logic                done;
	logic [asc_pkg::SAMPLE_W-1:0] read_value;
	logic [7:0]          mux_byte;
	logic                high_mux_bit;
	logic                start_next;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [7:0]          cfg_index = '0;
	logic [63:0]         cfg_data = '0;

	// predictor copy of configuration and state
	logic                en_scan = 1'b0;
	logic [63:0]         chan_table = asc_pkg::CHAN_TBL_RST;
	logic [7:0]          ref_bits = asc_pkg::REF_BITS_RST;
	logic                wide_mux = asc_pkg::WIDE_RST;
	logic [asc_pkg::SLOT_W-1:0]   slot_ptr = '0;
	logic [asc_pkg::SAMPLE_W-1:0] stored_sample [0:asc_pkg::TBL_SLOTS-1] = '{default: '0};

	scan_result_t        pending_scans [$];
	scan_result_t        head_scan;
	scan_result_t        got_scan;
	int                  mismatch_count = 0;
	int                  send_idle_pct = 0;
	int                  idle_cycles = 0;

	adc_scan_sequencer_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.sample(sample),
		.read_index(read_index),
		.done(done),
		.read_value(read_value),
		.mux_byte(mux_byte),
		.high_mux_bit(high_mux_bit),
		.start_next(start_next),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic scan_result_t predict_scan(asc_pkg::item_kind_t k,
			logic [asc_pkg::SAMPLE_W-1:0] smp, logic [7:0] idx);
		scan_result_t r;
		logic [7:0] ch;
		logic [asc_pkg::SLOT_W-1:0] cur;
		logic [asc_pkg::SLOT_W-1:0] cand;
		logic found;
		r = '0;
		found = 1'b0;
		cur = slot_ptr;
		if (k == asc_pkg::KIND_READ) begin
			ch = chan_table[idx[asc_pkg::SLOT_W-1:0]*8 +: 8];
			if (idx < asc_pkg::TBL_SLOTS &&
					ch < (wide_mux ? asc_pkg::CH_LIMIT_WIDE : asc_pkg::CH_LIMIT_NARROW))
				r.read_value = stored_sample[idx[asc_pkg::SLOT_W-1:0]];
		end else if (en_scan) begin
			stored_sample[cur] = smp;
			// search wraps all the way round, ending on the current slot
			for (int n = 1; n <= asc_pkg::TBL_SLOTS; n++) begin
				cand = cur + n[asc_pkg::SLOT_W-1:0];
				ch = chan_table[cand*8 +: 8];
				if (!found && ch != asc_pkg::CH_UNUSED) begin
					found = 1'b1;
					slot_ptr = cand;
					r.mux_byte = {5'b0, ch[2:0]} | ref_bits;
					r.high_mux_bit = wide_mux & ch[asc_pkg::CH_HIGH_BIT];
					r.start_next = 1'b1;
				end
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] random_channel_table();
		logic [63:0] t;
		int pick;
		pick = $urandom_range(99);
		if (pick < 8)
			t = asc_pkg::CHAN_TBL_RST;
		else if (pick < 12)
			t = '0;
		else if (pick < 22) begin
			t = asc_pkg::CHAN_TBL_RST;
			t[$urandom_range(asc_pkg::TBL_SLOTS-1)*8 +: 8] = 8'($urandom_range(0, 15));
		end else begin
			for (int s = 0; s < asc_pkg::TBL_SLOTS; s++) begin
				pick = $urandom_range(99);
				if (pick < 20)
					t[s*8 +: 8] = asc_pkg::CH_UNUSED;
				else if (pick < 85)
					t[s*8 +: 8] = 8'($urandom_range(0, 15));
				else
					t[s*8 +: 8] = 8'($urandom_range(0, 255));
			end
		end
		return t;
	endfunction

	// results arrive with a fixed strobe; the receiver has no way to stall
	always @(posedge clk) begin
		if (arst_n && done) begin
			got_scan = '{read_value, mux_byte, high_mux_bit, start_next};
			if (pending_scans.size() == 0) begin
				$display("%0t: unexpected result rv=%0d mux=%0h hi=%0b st=%0b", $time,
					read_value, mux_byte, high_mux_bit, start_next);
				mismatch_count++;
			end else begin
				head_scan = pending_scans.pop_front();
				if (got_scan !== head_scan) begin
					$display("%0t: expected rv=%0d mux=%0h hi=%0b st=%0b, got rv=%0d mux=%0h hi=%0b st=%0b",
						$time, head_scan.read_value, head_scan.mux_byte,
						head_scan.high_mux_bit, head_scan.start_next,
						read_value, mux_byte, high_mux_bit, start_next);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// drop start and wait for every outstanding result
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_scans.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_item(input asc_pkg::item_kind_t k,
			input logic [asc_pkg::SAMPLE_W-1:0] smp, input logic [7:0] idx);
		int gap;
		start <= 1'b1;
		kind <= k;
		sample <= smp;
		read_index <= idx;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_scans.push_back(predict_scan(k, smp, idx));
		gap = 0;
		if ($urandom_range(99) < send_idle_pct)
			gap = $urandom_range(1, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [63:0] data);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			asc_pkg::CFG_SCAN_ENABLE:    en_scan = data[0];
			asc_pkg::CFG_CHANNEL_TABLE:  chan_table = data;
			asc_pkg::CFG_REFERENCE_BITS: ref_bits = data[7:0];
			asc_pkg::CFG_WIDE_CHANNELS:  wide_mux = data[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic randomise_setup();
		int pick;
		write_reg(asc_pkg::CFG_SCAN_ENABLE, 64'($urandom_range(99) < 90));
		write_reg(asc_pkg::CFG_CHANNEL_TABLE, random_channel_table());
		pick = $urandom_range(99);
		write_reg(asc_pkg::CFG_REFERENCE_BITS, pick < 10 ? 64'd0 : pick < 20 ? 64'd255 :
			64'($urandom_range(0, 255)));
		write_reg(asc_pkg::CFG_WIDE_CHANNELS, 64'($urandom_range(1)));
	endtask

	// defaults after reset: scan off, all slots unused
	task automatic test_reset_state();
		send_item(asc_pkg::KIND_READ, '0, 8'd0);
		send_item(asc_pkg::KIND_CONVERSION, 10'h3FF, 8'd0);
		write_reg(asc_pkg::CFG_SCAN_ENABLE, 64'd1);
		// nothing in use: sample still lands in slot 0, no conversion started
		send_item(asc_pkg::KIND_CONVERSION, 10'h3FF, 8'hFF);
		write_reg(asc_pkg::CFG_CHANNEL_TABLE, 64'hFFFF_FFFF_FFFF_FF03);
		send_item(asc_pkg::KIND_READ, '0, 8'd0);
		// only the current slot in use: it is picked again
		send_item(asc_pkg::KIND_CONVERSION, 10'd0, 8'd0);
		send_item(asc_pkg::KIND_READ, 10'h3FF, 8'd0);
		settle();
	endtask

	task automatic test_register_extremes();
		write_reg(CFG_UNMAPPED, '1);
		write_reg(asc_pkg::CFG_CHANNEL_TABLE, 64'hFFFF_0010_0807_FF0F);
		write_reg(asc_pkg::CFG_REFERENCE_BITS, 64'd255);
		write_reg(asc_pkg::CFG_WIDE_CHANNELS, 64'd1);
		send_item(asc_pkg::KIND_CONVERSION, 10'h3FF, 8'd0);
		send_item(asc_pkg::KIND_CONVERSION, 10'd0, 8'd0);
		send_item(asc_pkg::KIND_CONVERSION, 10'd512, 8'd0);
		send_item(asc_pkg::KIND_CONVERSION, 10'd341, 8'd0);
		send_item(asc_pkg::KIND_CONVERSION, 10'd682, 8'd0);
		write_reg(asc_pkg::CFG_REFERENCE_BITS, 64'd0);
		send_item(asc_pkg::KIND_CONVERSION, 10'd777, 8'd0);
		send_item(asc_pkg::KIND_READ, '0, 8'd4);
		send_item(asc_pkg::KIND_READ, '0, 8'd3);
		send_item(asc_pkg::KIND_READ, '0, 8'd8);
		send_item(asc_pkg::KIND_READ, '0, 8'd255);
		send_item(asc_pkg::KIND_READ, '0, 8'd1);
		// narrow mode: channel 8 and 15 become invalid, high bit forced low
		write_reg(asc_pkg::CFG_WIDE_CHANNELS, 64'd0);
		send_item(asc_pkg::KIND_READ, '0, 8'd3);
		send_item(asc_pkg::KIND_READ, '0, 8'd0);
		send_item(asc_pkg::KIND_READ, '0, 8'd5);
		send_item(asc_pkg::KIND_CONVERSION, 10'd100, 8'd0);
		write_reg(asc_pkg::CFG_SCAN_ENABLE, 64'd0);
		send_item(asc_pkg::KIND_CONVERSION, 10'd200, 8'd0);
		send_item(asc_pkg::KIND_READ, '0, 8'd2);
		settle();
	endtask

	task automatic test_random_traffic(input int idle_pct, input int n_items);
		asc_pkg::item_kind_t k;
		logic [7:0] idx;
		send_idle_pct = idle_pct;
		for (int i = 0; i < n_items; i++) begin
			if (i % 45 == 0)
				randomise_setup();
			else if ($urandom_range(99) < 2)
				settle();
			k = ($urandom_range(99) < 40) ? asc_pkg::KIND_READ : asc_pkg::KIND_CONVERSION;
			idx = ($urandom_range(99) < 85) ? 8'($urandom_range(0, asc_pkg::TBL_SLOTS-1)) :
				8'($urandom_range(0, 255));
			send_item(k, 10'($urandom_range(0, 1023)), idx);
		end
		settle();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_register_extremes();
		test_random_traffic(0, 130);
		test_random_traffic(56, 130);
		test_random_traffic(0, 130);
		test_random_traffic(31, 130);
		settle();
		repeat (4) @(posedge clk);
		if (pending_scans.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_scans.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// ----- filelist.f -----
src/asc_pkg.sv
src/asc_ram.sv
src/adc_scan_sequencer_top.sv
verif/testbench.sv
